[rtl/core/rlq_pkg.sv]
// Shared types and codes for the line input ring deque.
package rlq_pkg;

  localparam int DEPTH_DEF = 256;
  localparam int KIND_W    = 3;
  localparam int DATA_W    = 8;
  localparam int STATUS_W  = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CHECK     = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd3;

  // decision made at accept, carried while the store read completes
  typedef struct packed {
    logic [STATUS_W-1:0] status;  // status known without the read data
    logic                pop;     // result data is the read byte
    logic                check;   // compare read byte against cmp
    logic [DATA_W-1:0]   cmp;
  } rlq_req_t;

endpackage

[rtl/core/rlq_if.sv]
// Valid/ready channel interfaces for requests and results.
interface rlq_in_if;
  import rlq_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output kind, output data_in, input ready);
  modport sink   (input valid, input kind, input data_in, output ready);
endinterface

interface rlq_out_if;
  import rlq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   data_out;

  modport source (output valid, output status, output data_out, input ready);
  modport sink   (input valid, input status, input data_out, output ready);
endinterface

[rtl/core/rlq_mem.sv]
// Byte store: one write port, one read port with registered read data.
module rlq_mem #(
  parameter int DEPTH = rlq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [rlq_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [rlq_pkg::DATA_W-1:0] rdata
);
  import rlq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

[rtl/core/rlq_ctrl.sv]
// Head/tail index control: decides each request and drives the store ports.
module rlq_ctrl #(
  parameter int DEPTH = rlq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [rlq_pkg::KIND_W-1:0]  kind,
  input  logic [rlq_pkg::DATA_W-1:0]  data_in,
  output logic                        we,
  output logic [AW-1:0]               waddr,
  output logic [rlq_pkg::DATA_W-1:0]  wdata,
  output logic                        re,
  output logic [AW-1:0]               raddr,
  output rlq_pkg::rlq_req_t           req,
  output logic [AW-1:0]               head_idx,
  output logic [AW-1:0]               tail_idx
);
  import rlq_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] next_h, next_t, prev_t;
  logic          empty, full;

  assign next_h = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign next_t = (tail_r == LAST) ? '0 : tail_r + 1'b1;
  assign prev_t = (tail_r == '0) ? LAST : tail_r - 1'b1;
  assign empty  = (head_r == tail_r);
  assign full   = (next_t == head_r);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    we         = 1'b0;
    waddr      = tail_r;
    wdata      = data_in;
    re         = 1'b0;
    raddr      = head_r;
    req.status = ST_OK;
    req.pop    = 1'b0;
    req.check  = 1'b0;
    req.cmp    = data_in;
    if (accept) begin
      case (kind)
        KIND_CLEAR: begin
          head_nxt = '0;
          tail_nxt = '0;
        end
        KIND_PUSH: begin
          if (full) begin
            req.status = ST_FULL;
          end else begin
            we       = 1'b1;
            tail_nxt = next_t;
          end
        end
        KIND_POP_FRONT: begin
          if (empty) begin
            req.status = ST_EMPTY;
          end else begin
            re       = 1'b1;
            req.pop  = 1'b1;
            head_nxt = next_h;
          end
        end
        KIND_POP_BACK: begin
          if (empty) begin
            req.status = ST_EMPTY;
          end else begin
            re       = 1'b1;
            raddr    = prev_t;
            req.pop  = 1'b1;
            tail_nxt = prev_t;
          end
        end
        KIND_CHECK: begin
          if (empty) begin
            req.status = ST_EMPTY;
          end else begin
            re        = 1'b1;
            raddr     = prev_t;
            req.check = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  assign head_idx = head_r;
  assign tail_idx = tail_r;
endmodule

[rtl/core/rlq_resp.sv]
// Read stage and result register; forms status and data from the store read.
module rlq_resp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  rlq_pkg::rlq_req_t             req,
  input  logic [rlq_pkg::DATA_W-1:0]    rdata,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rlq_pkg::STATUS_W-1:0]  out_status,
  output logic [rlq_pkg::DATA_W-1:0]    out_data
);
  import rlq_pkg::*;

  logic                a_valid_r;
  rlq_req_t            a_req_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [DATA_W-1:0]   data_r;
  logic                b_free, a_adv;

  assign b_free   = !out_valid_r || out_ready;
  assign a_adv    = a_valid_r && b_free;
  assign in_ready = !a_valid_r || b_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_req_r <= req;
    end
    if (a_adv) begin
      status_r <= (a_req_r.check && (rdata != a_req_r.cmp)) ? ST_MISMATCH : a_req_r.status;
      data_r   <= a_req_r.pop ? rdata : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_data   = data_r;
endmodule

[rtl/core/line_input_ring_deque_core.sv]
// Top level of the line input ring deque.
// Byte ring buffer for a terminal input line: DEPTH slots, at most DEPTH-1
// bytes held (one slot stays free so full and empty differ). Requests are
// clear, push, pop front, pop back (erase) and check tail; each request beat
// yields exactly one result beat. One request is taken every cycle while the
// read stage is empty or can move on; a result passes through the store's
// registered read port, loaded on the accepting edge, then the result register.
// The store is a DEPTH x 8 memory with one write and one read port; it has no
// clearing pass, since indices only ever point at written entries. Reset
// clears both indices.
module line_input_ring_deque_core #(
  parameter int DEPTH = rlq_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  rlq_in_if.sink           in_chan,
  rlq_out_if.source        out_chan
);
  import rlq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              in_ready;
  logic              accept;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;
  logic [AW-1:0]     head_idx, tail_idx;
  rlq_req_t          req;

  // a beat is taken when the read stage can move on or is empty
  assign accept        = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  // index control: decision and store port drive at accept
  rlq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .kind     (in_chan.kind),
    .data_in  (in_chan.data_in),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (re),
    .raddr    (raddr),
    .req      (req),
    .head_idx (head_idx),
    .tail_idx (tail_idx)
  );

  // byte store; read data held until the next read
  rlq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // read stage plus output register
  rlq_resp u_resp (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req        (req),
    .rdata      (rdata),
    .in_ready   (in_ready),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_status (out_chan.status),
    .out_data   (out_chan.data_out)
  );

  // one store access per beat at most
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(we && re))
    else $error("store written and read in the same cycle");

  // indices stay inside the ring
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(head_idx) < DEPTH) && (32'(tail_idx) < DEPTH))
    else $error("ring index out of range");

  // a push that was taken leaves the buffer non-empty
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> (head_idx != tail_idx))
    else $error("buffer empty right after a push");

  // store is touched only for a taken beat
  a_access_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (we || re) |-> accept)
    else $error("store access without an accepted beat");

endmodule

[dv/line_input_ring_deque_core_test.sv]
// Self-checking testbench for line_input_ring_deque_core: request driver, result sink, scoreboard.
module line_input_ring_deque_core_test;
  import rlq_pkg::*;

  // Ring geometry follows the block's default.
  localparam int DEPTH = DEPTH_DEF;

  // Kind codes the block must ignore (no state change, status ok).
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  localparam int PHASE_ITEMS  = 75;    // request beats per idling phase
  localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
  localparam int MAX_GAP      = 60;    // cap on one sender idle stretch
  localparam int DRAIN_CYCLES = 8;     // margin after the last expected result

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_out;
  } line_result_t;

  // Line-buffer scoreboard: mirrors the ring and queues the result each
  // accepted request must produce, in order.
  class line_scoreboard;
    logic [DATA_W-1:0] line_buf [DEPTH];
    int unsigned       head_slot;
    int unsigned       tail_slot;
    line_result_t      expected_q [$];
    int                errors;
    int                results;
    int                req_count;
    int                full_hits;
    int                empty_hits;
    int                mismatch_hits;
    int                tail_wraps;

    function new();
      head_slot     = 0;
      tail_slot     = 0;
      errors        = 0;
      results       = 0;
      req_count     = 0;
      full_hits     = 0;
      empty_hits    = 0;
      mismatch_hits = 0;
      tail_wraps    = 0;
    endfunction

    function int unsigned fill_level();
      return (tail_slot + DEPTH - head_slot) % DEPTH;
    endfunction

    // Newest byte; only meaningful while the line is not empty.
    function logic [DATA_W-1:0] last_byte();
      return line_buf[(tail_slot + DEPTH - 1) % DEPTH];
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] din);
      line_result_t res;
      int unsigned  back_slot;
      bit           is_empty;
      res.status    = ST_OK;
      res.data_out  = '0;
      back_slot     = (tail_slot + DEPTH - 1) % DEPTH;
      is_empty      = (head_slot == tail_slot);
      req_count++;
      case (kind)
        KIND_CLEAR: begin
          head_slot = 0;
          tail_slot = 0;
        end
        KIND_PUSH: begin
          if ((tail_slot + 1) % DEPTH == head_slot) begin
            res.status = ST_FULL;
          end else begin
            line_buf[tail_slot] = din;
            tail_slot = (tail_slot + 1) % DEPTH;
            if (tail_slot == 0) tail_wraps++;
          end
        end
        KIND_POP_FRONT: begin
          if (is_empty) begin
            res.status = ST_EMPTY;
          end else begin
            res.data_out = line_buf[head_slot];
            head_slot = (head_slot + 1) % DEPTH;
          end
        end
        KIND_POP_BACK: begin
          if (is_empty) begin
            res.status = ST_EMPTY;
          end else begin
            res.data_out = line_buf[back_slot];
            tail_slot = back_slot;
          end
        end
        KIND_CHECK: begin
          if (is_empty) begin
            res.status = ST_EMPTY;
          end else if (line_buf[back_slot] != din) begin
            res.status = ST_MISMATCH;
          end
        end
        default: ;
      endcase
      if (res.status == ST_FULL) full_hits++;
      if (res.status == ST_EMPTY) empty_hits++;
      if (res.status == ST_MISMATCH) mismatch_hits++;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] dout);
      line_result_t exp_res;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result beat with no request pending: status %0d data_out 0x%02h",
               status, dout);
        return;
      end
      exp_res = expected_q.pop_front();
      if (status !== exp_res.status) begin
        errors++;
        $error("status: expected %0d, got %0d", exp_res.status, status);
      end
      if (dout !== exp_res.data_out) begin
        errors++;
        $error("data_out: expected 0x%02h, got 0x%02h", exp_res.data_out, dout);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rlq_in_if  req_if ();
  rlq_out_if rsp_if ();

  line_scoreboard sb = new();

  int tx_idle_pct  = 0;  // chance per cycle that the sender sits idle
  int rx_stall_pct = 0;  // chance per cycle that the receiver stalls
  int hold_request = 0;  // nonzero asks the receiver for a long hold-off
  int item_count   = 0;  // request beats with a real kind code

  line_input_ring_deque_core #(
    .DEPTH (DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] rand_byte();
    return DATA_W'($urandom_range(0, 255));
  endfunction

  // Offer one request beat; returns at the edge where it is taken.
  // The expectation is logged here so the stimulus that follows sees
  // the updated ring without racing a separate monitor.
  task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] din);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.kind    <= kind;
    req_if.data_in <= din;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_request(kind, din);
    if (kind <= KIND_CHECK) item_count++;
  endtask

  // Tail check: half the time the true tail byte, sometimes one bit off,
  // otherwise any byte.
  task automatic send_check();
    logic [DATA_W-1:0] cmp;
    int                pick;
    pick = $urandom_range(0, 3);
    cmp  = rand_byte();
    if (sb.fill_level() != 0 && pick < 2) begin
      cmp = sb.last_byte();
    end else if (sb.fill_level() != 0 && pick == 2) begin
      cmp = sb.last_byte() ^ (DATA_W'(1) << $urandom_range(0, DATA_W - 1));
    end
    send_beat(KIND_CHECK, cmp);
  endtask

  // Typical line editing traffic: mostly typing, some erase and reads.
  task automatic send_mixed_beat();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_beat(KIND_PUSH, rand_byte());
    end else if (pick < 60) begin
      send_beat(KIND_POP_FRONT, rand_byte());
    end else if (pick < 75) begin
      send_beat(KIND_POP_BACK, rand_byte());
    end else if (pick < 95) begin
      send_check();
    end else if (pick < 97) begin
      send_beat(KIND_CLEAR, rand_byte());
    end else begin
      send_beat(KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)), rand_byte());
    end
  endtask

  // Type until the line is full, then keep typing into a full line.
  task automatic fill_to_full();
    while (sb.fill_level() < DEPTH - 1) begin
      if ($urandom_range(0, 9) == 0) send_check();
      else send_beat(KIND_PUSH, rand_byte());
    end
    repeat ($urandom_range(1, 3)) send_beat(KIND_PUSH, rand_byte());
    send_check();
  endtask

  // Read or erase until empty, then poke the empty line a couple of times.
  task automatic drain_to_empty();
    while (sb.fill_level() > 0) begin
      case ($urandom_range(0, 9))
        0:       send_check();
        1, 2, 3: send_beat(KIND_POP_BACK, rand_byte());
        default: send_beat(KIND_POP_FRONT, rand_byte());
      endcase
    end
    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(0, 1)) send_check();
      else send_beat($urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK, rand_byte());
    end
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input bit with_fill,
                           input bit with_hold);
    int goal;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    goal         = item_count + PHASE_ITEMS;
    // Hold-off first, with the sender still offering, so the pipeline backs up.
    if (with_hold) hold_request = HOLD_CYCLES;
    if (with_fill) begin
      fill_to_full();
      // clear over a full line; the random traffic that follows starts from an empty one
      send_beat(KIND_CLEAR, rand_byte());
    end
    while (item_count < goal) begin
      case ($urandom_range(0, 9))
        6: begin
          if (sb.fill_level() > DEPTH / 2) fill_to_full();
          else repeat ($urandom_range(10, 40)) send_mixed_beat();
        end
        7, 8: drain_to_empty();
        9: begin
          send_beat(KIND_CLEAR, rand_byte());
          repeat ($urandom_range(3, 10)) send_mixed_beat();
        end
        default: repeat ($urandom_range(10, 40)) send_mixed_beat();
      endcase
    end
  endtask

  // Result side: random stalls, plus the long hold-off on request.
  initial begin : rsp_sink
    int hold_left;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      sb.check_result(rsp_if.status, rsp_if.data_out);
    end
  end

  // Watchdog: ends a run that stops moving beats on both channels.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat for %0d cycles", STALL_LIMIT);
    $display("line_input_ring_deque_core verification failed");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.kind    = KIND_CLEAR;
    req_if.data_in = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-line requests, extreme bytes, both pop ends,
    // match and mismatch, ignored kinds, clear over live contents.
    send_beat(KIND_POP_FRONT, 8'hff);
    send_beat(KIND_POP_BACK, 8'h00);
    send_beat(KIND_CHECK, 8'h00);
    send_beat(KIND_PUSH, 8'h00);
    send_beat(KIND_CHECK, 8'h00);
    send_beat(KIND_CHECK, 8'hff);
    send_beat(KIND_PUSH, 8'hff);
    send_beat(KIND_PUSH, 8'ha5);
    send_beat(KIND_POP_BACK, 8'h00);
    send_beat(KIND_CHECK, 8'hff);
    send_beat(KIND_POP_FRONT, 8'h00);
    send_beat(KIND_POP_FRONT, 8'h00);
    send_beat(KIND_POP_FRONT, 8'h00);
    send_beat(KIND_PUSH, 8'h5a);
    send_beat(KIND_PUSH, 8'h81);
    send_beat(KIND_SPARE_FIRST, 8'hff);
    send_beat(KIND_SPARE_MID, 8'h00);
    send_beat(KIND_SPARE_LAST, 8'haa);
    send_beat(KIND_CHECK, 8'h81);
    send_beat(KIND_CLEAR, 8'hff);
    send_beat(KIND_POP_BACK, 8'h00);
    send_beat(KIND_PUSH, 8'h7e);
    send_beat(KIND_CHECK, 8'h7e);
    send_beat(KIND_POP_BACK, 8'h00);

    // Random phases: none / sender idle / receiver stall / both.
    run_phase(0, 0, 1'b1, 1'b1);
    run_phase(85, 0, 1'b0, 1'b0);
    run_phase(0, 85, 1'b0, 1'b1);
    run_phase(22, 22, 1'b0, 1'b0);

    req_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests checked against %0d results; line full %0d times, empty %0d,",
             sb.req_count, sb.results, sb.full_hits, sb.empty_hits);
    $display("tail mismatch %0d, tail index wrapped %0d times, %0d errors",
             sb.mismatch_hits, sb.tail_wraps, sb.errors);
    if (sb.errors == 0) begin
      $display("line_input_ring_deque_core verification clean");
    end else begin
      $display("line_input_ring_deque_core verification failed");
    end
    $finish;
  end

endmodule
